### hw/rtl/assert_macros.svh
// Assertion macros used by the result-channel checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, held off while arst_n is low.
`define B64_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, clocked on clk, held off while arst_n is low.
`define B64_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

### hw/rtl/b64_pkg.sv
// Shared types, status codes and the alphabet lookup for the base64 decoder.
package b64_pkg;

	localparam logic [1:0] ST_DATA   = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_BADLEN = 2'd2;
	localparam logic [1:0] ST_BADCHR = 2'd3;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [6:0] BAD_SEXTET = 7'd64;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} res_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'; anything else is BAD_SEXTET.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		case (c) inside
			[8'h41:8'h5A]: v = 7'(c - 8'h41);
			[8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
			8'h2B:         v = 7'd62;
			8'h2F:         v = 7'd63;
			default:       v = BAD_SEXTET;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/b64_char_if.sv
// Character channel: one encoded character per beat, with end-of-message mark.
interface b64_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

### hw/rtl/b64_res_if.sv
// Result channel: one decoded byte or one message status per beat.
interface b64_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [1:0]  status;
	logic [31:0] err_offset;
	logic [31:0] msg_bytes;
	logic        last;

	modport source (output valid, output data_byte, output status, output err_offset,
		output msg_bytes, output last, input ready);
	modport sink   (input valid, input data_byte, input status, input err_offset,
		input msg_bytes, input last, output ready);
endinterface

### hw/rtl/base64_stream_decoder.sv
// A taken character is registered in the input stage; its result beats (up to four)
// then load the buffer that drives the single result port. One character per
// cycle while the buffer is free, else one with result beats waits until it drains.
// Characters that yield no result pass through even while a result beat is stalled.
// Reset: arst_n clears the group and message state, the input stage and the result
// buffer at once; the block is ready for characters as soon as reset is released.
module base64_stream_decoder #(
	parameter int COUNT_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	b64_char_if.sink   chars,
	b64_res_if.source  results
);
	import b64_pkg::*;

	// ---------------- input stage ----------------
	logic       vld_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// ---------------- message state ----------------
	logic [6:0]             sext_q [3];
	logic                   tpad_q;    // position three of the group was '='
	logic [1:0]             pos_q;     // place of the next character in its group
	logic [COUNT_WIDTH-1:0] ccnt_q;    // characters seen in this message
	logic [COUNT_WIDTH-1:0] bcnt_q;    // bytes emitted in this message
	logic                   drop_q;    // error seen, discarding to message end

	// ---------------- result buffer ----------------
	// Holds all result beats of one character; beat 0 drives the port.
	res_t        bat_q [4];
	logic [2:0]  bat_cnt_q;
	logic [31:0] bat_off_q;
	logic [31:0] bat_tot_q;

	// ---------------- decode ----------------
	logic [6:0]             v;
	logic                   pad;
	logic                   bad;
	logic [23:0]            word;
	res_t                   nres [4];
	logic [2:0]             nn;
	logic [6:0]             nxt_sext [3];
	logic                   nxt_tpad;
	logic [1:0]             nxt_pos;
	logic [COUNT_WIDTH-1:0] nxt_ccnt;
	logic [COUNT_WIDTH-1:0] nxt_bcnt;
	logic                   nxt_drop;
	logic [COUNT_WIDTH-1:0] tot_n;
	logic [63:0]            ccnt_ext;
	logic [63:0]            tot_ext;

	logic pop;
	logic take;

	always_comb begin
		v    = sextet_of(char_s1);
		pad  = (char_s1 == PAD_CHAR);
		word = {sext_q[0][5:0], sext_q[1][5:0], sext_q[2][5:0], pad ? 6'd0 : v[5:0]};

		// '=' is only legal in positions three and four, and after '=' in position
		// three only another '=' may follow.
		if (pos_q == 2'd3)
			bad = ((v == BAD_SEXTET) && !pad) || (tpad_q && !pad);
		else if (pos_q == 2'd2)
			bad = (v == BAD_SEXTET) && !pad;
		else
			bad = (v == BAD_SEXTET);

		for (int i = 0; i < 4; i++)
			nres[i] = '0;
		nn = 3'd0;
		for (int i = 0; i < 3; i++)
			nxt_sext[i] = sext_q[i];
		nxt_tpad = tpad_q;
		nxt_pos  = pos_q;
		nxt_ccnt = ccnt_q;
		nxt_bcnt = bcnt_q;
		nxt_drop = drop_q;
		tot_n    = bcnt_q;

		if (drop_q) begin
			if (last_s1) begin
				for (int i = 0; i < 3; i++)
					nxt_sext[i] = '0;
				nxt_tpad = 1'b0;
				nxt_pos  = 2'd0;
				nxt_ccnt = '0;
				nxt_bcnt = '0;
				nxt_drop = 1'b0;
			end
		end else begin
			nxt_ccnt = ccnt_q + COUNT_WIDTH'(1);
			if (bad) begin
				nres[0] = {8'd0, ST_BADCHR, 1'b1};
				nn      = 3'd1;
				nxt_drop = 1'b1;
			end else begin
				if (pos_q != 2'd3) begin
					nxt_sext[pos_q] = pad ? 7'd0 : v;
					if (pos_q == 2'd2)
						nxt_tpad = pad;
					nxt_pos = pos_q + 2'd1;
				end else begin
					nres[nn[1:0]] = {word[23:16], ST_DATA, 1'b0};
					nn = nn + 3'd1;
					if (!tpad_q) begin
						nres[nn[1:0]] = {word[15:8], ST_DATA, 1'b0};
						nn = nn + 3'd1;
					end
					if (!pad) begin
						nres[nn[1:0]] = {word[7:0], ST_DATA, 1'b0};
						nn = nn + 3'd1;
					end
					nxt_bcnt = bcnt_q + COUNT_WIDTH'(nn);
					nxt_pos  = 2'd0;
					nxt_tpad = 1'b0;
				end
				tot_n = nxt_bcnt;
				if (last_s1) begin
					if (pos_q == 2'd3)
						nres[nn[1:0]] = {8'd0, ST_DONE, 1'b1};
					else
						nres[nn[1:0]] = {8'd0, ST_BADLEN, 1'b1};
					nn = nn + 3'd1;
				end
			end
			// message end always leaves a clean slate
			if (last_s1) begin
				for (int i = 0; i < 3; i++)
					nxt_sext[i] = '0;
				nxt_tpad = 1'b0;
				nxt_pos  = 2'd0;
				nxt_ccnt = '0;
				nxt_bcnt = '0;
				nxt_drop = 1'b0;
			end
		end
	end

	assign ccnt_ext = 64'(ccnt_q);
	assign tot_ext  = 64'(tot_n);

	// ---------------- handshakes ----------------
	assign pop  = results.valid && results.ready;
	// A character moves on when it yields nothing, or the buffer is free by this edge.
	assign take = vld_s1 && ((nn == 3'd0) || (bat_cnt_q == 3'd0) ||
		((bat_cnt_q == 3'd1) && pop));
	assign chars.ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (chars.valid && chars.ready) || (vld_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				sext_q[i] <= '0;
			tpad_q <= 1'b0;
			pos_q  <= 2'd0;
			ccnt_q <= '0;
			bcnt_q <= '0;
			drop_q <= 1'b0;
		end else if (take) begin
			for (int i = 0; i < 3; i++)
				sext_q[i] <= nxt_sext[i];
			tpad_q <= nxt_tpad;
			pos_q  <= nxt_pos;
			ccnt_q <= nxt_ccnt;
			bcnt_q <= nxt_bcnt;
			drop_q <= nxt_drop;
		end
	end

	// ---------------- result buffer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bat_cnt_q <= 3'd0;
		end else if (take && (nn != 3'd0)) begin
			bat_cnt_q <= nn;
		end else if (pop) begin
			bat_cnt_q <= bat_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && (nn != 3'd0)) begin
			for (int i = 0; i < 4; i++)
				bat_q[i] <= nres[i];
			bat_off_q <= ccnt_ext[31:0];
			bat_tot_q <= tot_ext[31:0];
		end else if (pop) begin
			for (int i = 0; i < 3; i++)
				bat_q[i] <= bat_q[i+1];
			bat_q[3] <= '0;
		end
	end

	assign results.valid      = (bat_cnt_q != 3'd0);
	assign results.data_byte  = bat_q[0].data;
	assign results.status     = bat_q[0].status;
	assign results.last       = bat_q[0].last;
	assign results.err_offset = (bat_q[0].status == ST_BADCHR) ? bat_off_q : 32'd0;
	assign results.msg_bytes  = (bat_q[0].status == ST_DONE) ? bat_tot_q : 32'd0;

endmodule

### hw/rtl/b64_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
`include "assert_macros.svh"

module b64_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  status,
	input logic [31:0] err_offset,
	input logic [31:0] msg_bytes,
	input logic        last
);
	import b64_pkg::*;

	// only status beats close a message
	`B64_ASSERT_IMP(a_last_on_status, res_valid, last == (status != ST_DATA))
	`B64_ASSERT_IMP(a_offset_only_badchr, res_valid && (status != ST_BADCHR), err_offset == 32'd0)
	`B64_ASSERT_IMP(a_total_only_done, res_valid && (status != ST_DONE), msg_bytes == 32'd0)
	`B64_ASSERT_NXT(a_stall_holds, res_valid && !res_ready, res_valid)

endmodule

bind base64_stream_decoder b64_checker u_b64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.status     (results.status),
	.err_offset (results.err_offset),
	.msg_bytes  (results.msg_bytes),
	.last       (results.last)
);

### tb/base64_stream_decoder_check.sv
// Checker for the base64 decoder: watches both channels, predicts result beats and compares them.
module base64_stream_decoder_check (
	input  logic        clk,
	input  logic        arst_n,
	b64_char_if         chars,
	b64_res_if          results,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned decoded_chars
);
	import b64_pkg::*;

	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  status;
		logic [31:0] offset;
		logic [31:0] total;
		logic        last;
	} beat_t;

	beat_t       due_beats[$];
	logic [6:0]  held[3];
	logic        third_pad;
	logic [1:0]  slot;
	logic [31:0] char_total;
	logic [31:0] byte_total;
	logic        skipping;
	int unsigned miss_count;
	int unsigned used_count;

	function automatic logic [6:0] alphabet_index(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 7'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'h61 + 8'd26);
		if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
		if (c == 8'h2B) return 7'd62;
		if (c == 8'h2F) return 7'd63;
		return BAD_SEXTET;
	endfunction

	function automatic beat_t make_beat(input logic [7:0] data, input logic [1:0] status,
		input logic [31:0] offset, input logic [31:0] total, input logic last);
		beat_t b;
		b.data   = data;
		b.status = status;
		b.offset = offset;
		b.total  = total;
		b.last   = last;
		return b;
	endfunction

	task automatic clear_message();
		held[0]    = '0;
		held[1]    = '0;
		held[2]    = '0;
		third_pad  = 1'b0;
		slot       = 2'd0;
		char_total = '0;
		byte_total = '0;
		skipping   = 1'b0;
	endtask

	// one accepted character: queue the result beats it causes
	task automatic take_char(input logic [7:0] c, input logic eom);
		logic [6:0]  v;
		logic [6:0]  d;
		logic        pad;
		logic        bad;
		logic [1:0]  pos;
		logic [31:0] off;
		logic [23:0] word;
		int          n;
		used_count++;
		if (skipping) begin
			if (eom) clear_message();
			return;
		end
		pos = slot;
		off = char_total;
		char_total++;
		v   = alphabet_index(c);
		pad = (c == PAD_CHAR);
		case (pos)
			2'd0, 2'd1: bad = (v == BAD_SEXTET);
			2'd2:       bad = (v == BAD_SEXTET) && !pad;
			default:    bad = ((v == BAD_SEXTET) && !pad) || (third_pad && !pad);
		endcase
		if (bad) begin
			due_beats.push_back(make_beat(8'h00, ST_BADCHR, off, 32'd0, 1'b1));
			if (eom) clear_message();
			else skipping = 1'b1;
			return;
		end
		if (pos != 2'd3) begin
			held[pos] = pad ? 7'd0 : v;
			if (pos == 2'd2) third_pad = pad;
			slot = pos + 2'd1;
		end else begin
			d    = pad ? 7'd0 : v;
			word = {held[0][5:0], held[1][5:0], held[2][5:0], d[5:0]};
			n    = 1;
			due_beats.push_back(make_beat(word[23:16], ST_DATA, 32'd0, 32'd0, 1'b0));
			if (!third_pad) begin
				due_beats.push_back(make_beat(word[15:8], ST_DATA, 32'd0, 32'd0, 1'b0));
				n++;
			end
			if (!pad) begin
				due_beats.push_back(make_beat(word[7:0], ST_DATA, 32'd0, 32'd0, 1'b0));
				n++;
			end
			byte_total = byte_total + 32'(n);
			slot       = 2'd0;
			third_pad  = 1'b0;
		end
		if (eom) begin
			if (pos == 2'd3) due_beats.push_back(make_beat(8'h00, ST_DONE, 32'd0, byte_total, 1'b1));
			else due_beats.push_back(make_beat(8'h00, ST_BADLEN, 32'd0, 32'd0, 1'b1));
			clear_message();
		end
	endtask

	task automatic report_miss(input string what, input beat_t want, input beat_t got);
		miss_count++;
		if (miss_count <= 10) begin
			$display("%s: expected data %h status %0d offset %0d total %0d last %b", what,
				want.data, want.status, want.offset, want.total, want.last);
			$display("  got data %h status %0d offset %0d total %0d last %b",
				got.data, got.status, got.offset, got.total, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t got;
		beat_t want;
		if (!arst_n) begin
			clear_message();
			due_beats.delete();
			miss_count    = 0;
			used_count    = 0;
			mismatches    <= 0;
			outstanding   <= 0;
			decoded_chars <= 0;
		end else begin
			if (chars.valid && chars.ready) take_char(chars.char_in, chars.last_char);
			if (results.valid && results.ready) begin
				got = make_beat(results.data_byte, results.status, results.err_offset,
					results.msg_bytes, results.last);
				if (due_beats.size() == 0) begin
					report_miss("unexpected beat", '0, got);
				end else begin
					want = due_beats.pop_front();
					if (got != want) report_miss("mismatch", want, got);
				end
			end
			mismatches    <= miss_count;
			outstanding   <= due_beats.size();
			decoded_chars <= used_count;
		end
	end

endmodule

### tb/base64_stream_decoder_test.sv
// Top of the base64 decoder testbench: clock, reset, character stimulus and the verdict.
module base64_stream_decoder_test;
	import b64_pkg::*;

	logic        clk;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned decoded_chars;

	// idle rates in percent per cycle, changed between phases
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// characters of the message being built
	logic [7:0] msg[$];

	b64_char_if din();
	b64_res_if  dout();

	base64_stream_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (din),
		.results (dout)
	);

	base64_stream_decoder_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (din),
		.results       (dout),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.decoded_chars (decoded_chars)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver back-pressure: ready is redrawn every cycle at the current idle rate.
	initial begin
		dout.ready = 1'b0;
		forever begin
			@(posedge clk);
			dout.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hard stop in case the block hangs or loses beats.
	initial begin
		#3000000;
		$display("FAIL base64_stream_decoder");
		$finish;
	end

	// Sextet index to its alphabet character.
	function automatic logic [7:0] alpha_char(input int unsigned idx);
		if (idx < 26) return 8'(8'h41 + idx);
		if (idx < 52) return 8'(8'h61 + idx - 26);
		if (idx < 62) return 8'(8'h30 + idx - 52);
		if (idx == 62) return 8'h2B;
		return 8'h2F;
	endfunction

	// One character beat. Valid stays high after acceptance so that back-to-back
	// beats need no second assignment in the same step; gaps lower it first.
	task automatic send_beat(input logic [7:0] c, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid     <= 1'b1;
		din.char_in   <= c;
		din.last_char <= eom;
		do @(posedge clk); while (!din.ready);
	endtask

	task automatic send_text(input string s, input bit eom);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], eom && (i == s.len() - 1));
	endtask

	// Hold the sender off until every predicted result beat has come back.
	task automatic drain();
		din.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Mostly well-formed messages with random content; the rest is corrupted
	// by a stray byte, a misplaced pad, a wrong length or pure noise.
	task automatic build_message();
		int unsigned groups;
		int unsigned kind;
		int unsigned n;
		msg.delete();
		groups = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
		for (int g = 0; g < groups; g++) begin
			repeat (4) msg.push_back(alpha_char($urandom_range(63)));
			// padding mostly on the final group, now and then on an inner one
			if (g == groups - 1 || $urandom_range(9) == 0) begin
				n = msg.size();
				case ($urandom_range(3))
					1: msg[n-1] = PAD_CHAR;
					2: begin
						msg[n-1] = PAD_CHAR;
						msg[n-2] = PAD_CHAR;
					end
					default: ;
				endcase
			end
		end
		kind = $urandom_range(99);
		if (kind < 68) begin
			// clean message
		end else if (kind < 78) begin
			msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
		end else if (kind < 85) begin
			msg[$urandom_range(msg.size() - 1)] = PAD_CHAR;
		end else if (kind < 92) begin
			repeat ($urandom_range(1, 3)) msg.push_back(alpha_char($urandom_range(63)));
		end else if (kind < 96) begin
			repeat ($urandom_range(1, 3)) if (msg.size() > 1) void'(msg.pop_back());
		end else begin
			msg.delete();
			repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(255)));
		end
	endtask

	initial begin
		int phase;
		arst_n        = 1'b0;
		din.valid     = 1'b0;
		din.char_in   = 8'h00;
		din.last_char = 1'b0;
		send_idle_pct = 26;
		recv_idle_pct = 45;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single and double pad on inner groups, then a group of alphabet
		// extremes, closing with done.
		send_text("TWE=", 0);
		send_text("TQ==", 0);
		send_text("/+9z", 1);
		// pad in the first position, the rest of the message is dropped
		send_text("=", 0);
		send_text("A", 1);
		// data after a pad in position three
		send_text("AB=C", 1);
		// invalid last character: only the character error, no length error
		send_text("AB", 0);
		send_beat(8'h00, 1);
		// all-ones byte up front, then a dropped final beat
		send_beat(8'hFF, 0);
		send_text("A", 1);
		// length not a multiple of four
		send_text("ABC", 1);

		// Random messages in three idling phases; the sender drains at each change.
		phase = 0;
		while (decoded_chars < 260) begin
			if (phase == 0 && decoded_chars >= 105) begin
				drain();
				send_idle_pct = 45;
				recv_idle_pct = 26;
				phase         = 1;
			end else if (phase == 1 && decoded_chars >= 180) begin
				drain();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				phase         = 2;
			end
			build_message();
			foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
		end

		// Wait for every result, then idle on to catch stray beats.
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS base64_stream_decoder");
		end else begin
			$display("FAIL base64_stream_decoder");
		end
		$finish;
	end

endmodule
